@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/dshsd_pkg.sv @@
// ----------------------------------------------------------------------------
// dshsd_pkg
// Types, constants and lookup functions of the dual stepper half-step driver.
// ----------------------------------------------------------------------------
package dshsd_pkg;

    localparam int NUM_PINS_DEF   = 28;
    localparam int STEP_BITS_DEF  = 16;
    localparam int DELAY_BITS_DEF = 20;
    localparam int COUNT_BITS_DEF = 32;

    // Width of the pin level port.
    localparam int PIN_LEVEL_BITS = 28;

    // Counter memory geometry: eight rows of four counters each.
    localparam int MEM_ROWS  = 8;
    localparam int MEM_LANES = 4;
    localparam int ROW_BITS  = $clog2(MEM_ROWS);
    localparam int LANE_BITS = $clog2(MEM_LANES);

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_MOVE  = 2'd1,
        OP_SET   = 2'd2,
        OP_QUERY = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_BUSY  = 2'd2
    } status_t;

    // Request to the counter memory, issued when an accepted beat steps, sets or queries.
    typedef struct packed {
        logic                 en;
        logic [ROW_BITS-1:0]  row;
        logic [MEM_LANES-1:0] inc_mask;
        logic [LANE_BITS-1:0] qlane;
    } cnt_req_t;

    // Coil pattern of a half-step phase; bit k drives coil k.
    function automatic logic [3:0] phase_row(input logic [2:0] phase);
        logic [3:0] row;
        case (phase)
            3'd0:    row = 4'b1001;
            3'd1:    row = 4'b0001;
            3'd2:    row = 4'b0011;
            3'd3:    row = 4'b0010;
            3'd4:    row = 4'b0110;
            3'd5:    row = 4'b0100;
            3'd6:    row = 4'b1100;
            3'd7:    row = 4'b1000;
            default: row = 4'b0000;
        endcase
        return row;
    endfunction

    // Pin number of coil k of a motor.
    function automatic logic [4:0] motor_pin(input logic axis, input logic [1:0] k);
        logic [4:0] pin;
        case ({axis, k})
            3'b000:  pin = 5'd14;
            3'b001:  pin = 5'd15;
            3'b010:  pin = 5'd18;
            3'b011:  pin = 5'd23;
            3'b100:  pin = 5'd17;
            3'b101:  pin = 5'd4;
            3'b110:  pin = 5'd27;
            3'b111:  pin = 5'd22;
            default: pin = 5'd0;
        endcase
        return pin;
    endfunction

    // Placement of a pin's write counter: {row, lane}. The four pins of each
    // motor share one row, in coil order, so a step touches a single row.
    function automatic logic [ROW_BITS+LANE_BITS-1:0] pin_slot(input logic [4:0] pin);
        logic [ROW_BITS+LANE_BITS-1:0] slot;
        case (pin)
            5'd14:   slot = {3'd0, 2'd0};
            5'd15:   slot = {3'd0, 2'd1};
            5'd18:   slot = {3'd0, 2'd2};
            5'd23:   slot = {3'd0, 2'd3};
            5'd17:   slot = {3'd1, 2'd0};
            5'd4:    slot = {3'd1, 2'd1};
            5'd27:   slot = {3'd1, 2'd2};
            5'd22:   slot = {3'd1, 2'd3};
            5'd0:    slot = {3'd2, 2'd0};
            5'd1:    slot = {3'd2, 2'd1};
            5'd2:    slot = {3'd2, 2'd2};
            5'd3:    slot = {3'd2, 2'd3};
            5'd5:    slot = {3'd3, 2'd0};
            5'd6:    slot = {3'd3, 2'd1};
            5'd7:    slot = {3'd3, 2'd2};
            5'd8:    slot = {3'd3, 2'd3};
            5'd9:    slot = {3'd4, 2'd0};
            5'd10:   slot = {3'd4, 2'd1};
            5'd11:   slot = {3'd4, 2'd2};
            5'd12:   slot = {3'd4, 2'd3};
            5'd13:   slot = {3'd5, 2'd0};
            5'd16:   slot = {3'd5, 2'd1};
            5'd19:   slot = {3'd5, 2'd2};
            5'd20:   slot = {3'd5, 2'd3};
            5'd21:   slot = {3'd6, 2'd0};
            5'd24:   slot = {3'd6, 2'd1};
            5'd25:   slot = {3'd6, 2'd2};
            5'd26:   slot = {3'd6, 2'd3};
            5'd28:   slot = {3'd7, 2'd0};
            5'd29:   slot = {3'd7, 2'd1};
            5'd30:   slot = {3'd7, 2'd2};
            5'd31:   slot = {3'd7, 2'd3};
            default: slot = {3'd7, 2'd3};
        endcase
        return slot;
    endfunction

endpackage

@@ hdl/dshsd_count_mem.sv @@
// ----------------------------------------------------------------------------
// dshsd_count_mem
// Per-pin write counters in a row-organized memory with read-modify-write.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dshsd_count_mem #(
    parameter int COUNT_BITS = dshsd_pkg::COUNT_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dshsd_pkg::cnt_req_t   req,
    output logic [COUNT_BITS-1:0] cnt
);

    typedef logic [dshsd_pkg::MEM_LANES-1:0][COUNT_BITS-1:0] row_t;

    row_t                             mem [dshsd_pkg::MEM_ROWS];
    logic [dshsd_pkg::MEM_ROWS-1:0]   row_valid_reg;
    dshsd_pkg::cnt_req_t              req_reg;
    row_t                             rd_data_reg;
    logic                             rd_valid_reg;
    logic                             wr_valid_reg;
    logic [dshsd_pkg::ROW_BITS-1:0]   wr_row_reg;
    row_t                             wr_data_reg;

    row_t cur_row;
    row_t new_row;
    logic wr_en;

    // A row never written reads as zero. The write of the previous request
    // lands at the same edge as this request's read, so it is forwarded.
    always_comb
    begin
        if (wr_valid_reg && (wr_row_reg == req_reg.row))
        begin
            cur_row = wr_data_reg;
        end
        else if (rd_valid_reg)
        begin
            cur_row = rd_data_reg;
        end
        else
        begin
            cur_row = '0;
        end
        for (int k = 0; k < dshsd_pkg::MEM_LANES; k++)
        begin
            new_row[k] = cur_row[k] + COUNT_BITS'(req_reg.inc_mask[k]);
        end
        wr_en = req_reg.en && (req_reg.inc_mask != '0);
        cnt   = cur_row[req_reg.qlane];
    end

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            rd_data_reg <= mem[req.row];
        end
        if (wr_en)
        begin
            mem[req_reg.row] <= new_row;
        end
        wr_row_reg  <= req_reg.row;
        wr_data_reg <= new_row;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            wr_valid_reg  <= 1'b0;
            row_valid_reg <= '0;
        end
        else
        begin
            req_reg      <= req;
            wr_valid_reg <= wr_en;
            if (req.en)
            begin
                rd_valid_reg <= row_valid_reg[req.row];
            end
            if (wr_en)
            begin
                row_valid_reg[req_reg.row] <= 1'b1;
            end
        end
    end

    `ASSERT_ALWAYS(a_written_row_valid, !wr_valid_reg || row_valid_reg[wr_row_reg], "written row not marked valid")
    `ASSERT_NEXT(a_req_follows, req.en, req_reg.en, "memory request lost")
    `ASSERT_ALWAYS(a_write_has_req, !wr_en || req_reg.en, "write without request")

endmodule

@@ hdl/dual_stepper_half_step_driver.sv @@
// ----------------------------------------------------------------------------
// dual_stepper_half_step_driver
// Two four-coil half-step motor sequencers with direct pin control.
// ----------------------------------------------------------------------------
// Usage: commands enter on the input channel (in_valid, in_stall) as one beat
// each: a tick, a motor move, a pin set or a pin query. Every input beat gives
// exactly one result beat on the output channel (out_valid, out_stall), in
// order, carrying the pin levels, the busy flag, the operation count, the
// queried write count and a status code.
// An accepted beat is registered in the memory stage and then written into the
// output queue; out_valid rises once the result is in the queue.
// Throughput is one beat per cycle while out_stall is low; the counter memory's
// read-modify-write makes at most one row access per beat, with the last write
// forwarded to the next read.
// Reset clears the phases, pin levels, counters and move state at once; the
// counter memory uses per-row valid bits, so no clearing pass is needed.
// When the receiver stalls, results wait in a two-entry output queue.
// in_stall rises once the beats in the memory stage and the queue together
// take up both queue entries and the receiver is not taking one this cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dual_stepper_half_step_driver #(
    parameter int NUM_PINS   = dshsd_pkg::NUM_PINS_DEF,
    parameter int STEP_BITS  = dshsd_pkg::STEP_BITS_DEF,
    parameter int DELAY_BITS = dshsd_pkg::DELAY_BITS_DEF,
    parameter int COUNT_BITS = dshsd_pkg::COUNT_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          operation,
    input  logic                                axis,
    input  logic signed [STEP_BITS-1:0]         step_count,
    input  logic [DELAY_BITS-1:0]               step_delay,
    input  logic [4:0]                          pin_number,
    input  logic                                pin_value,

    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [dshsd_pkg::PIN_LEVEL_BITS-1:0] pin_levels,
    output logic                                busy_res,
    output logic [COUNT_BITS-1:0]               ops_total,
    output logic [COUNT_BITS-1:0]               pin_write_count,
    output logic [1:0]                          status
);

    localparam int LVB = dshsd_pkg::PIN_LEVEL_BITS;

    // Control state of the motors and pins.
    logic [2:0]            x_phase_reg, x_phase_next;
    logic [2:0]            y_phase_reg, y_phase_next;
    logic [NUM_PINS-1:0]   levels_reg, levels_next;
    logic [COUNT_BITS-1:0] ops_reg, ops_next;
    logic                  move_active_reg, move_active_next;
    logic                  move_axis_reg, move_axis_next;
    logic                  move_reverse_reg, move_reverse_next;
    logic [STEP_BITS-1:0]  steps_left_reg, steps_left_next;
    logic [DELAY_BITS-1:0] wait_counter_reg, wait_counter_next;
    logic [DELAY_BITS-1:0] wait_reload_reg, wait_reload_next;
    dshsd_pkg::status_t    status_next;

    // Memory stage: the result waits here for the counter read.
    logic                  s1_valid_reg;
    logic [LVB-1:0]        s1_levels_reg;
    logic                  s1_busy_reg;
    logic [COUNT_BITS-1:0] s1_ops_reg;
    dshsd_pkg::status_t    s1_status_reg;
    logic                  s1_query_reg;
    logic [COUNT_BITS-1:0] mem_cnt;

    // Output queue, two entries.
    logic [LVB-1:0]        q_levels [2];
    logic                  q_busy   [2];
    logic [COUNT_BITS-1:0] q_ops    [2];
    logic [COUNT_BITS-1:0] q_cnt    [2];
    dshsd_pkg::status_t    q_status [2];
    logic                  q_head_reg, q_tail_reg;
    logic [1:0]            q_cnt_reg;
    logic [1:0]            occ;
    logic                  pop;
    logic                  accept;

    dshsd_pkg::op_t        op;
    dshsd_pkg::cnt_req_t   req;
    logic                  do_step, do_finish, set_wr, query;
    logic                  step_axis, step_rev;
    logic [2:0]            phase, phase_new;
    logic [3:0]            coil_bits;
    logic [DELAY_BITS-1:0] wc_dec;
    logic [STEP_BITS-1:0]  cnt_u, mag;
    logic                  pin_bad;
    logic [4:0]            mpin;
    logic [dshsd_pkg::ROW_BITS+dshsd_pkg::LANE_BITS-1:0] slot, step_slot;
    logic [31:0]           levels_wide;

    assign pop       = out_valid && !out_stall;
    assign occ       = q_cnt_reg + {1'b0, s1_valid_reg};
    assign in_stall  = (occ == 2'd2) && !pop;
    assign accept    = in_valid && !in_stall;

    always_comb
    begin
        op                = dshsd_pkg::op_t'(operation);
        x_phase_next      = x_phase_reg;
        y_phase_next      = y_phase_reg;
        levels_next       = levels_reg;
        ops_next          = ops_reg;
        move_active_next  = move_active_reg;
        move_axis_next    = move_axis_reg;
        move_reverse_next = move_reverse_reg;
        steps_left_next   = steps_left_reg;
        wait_counter_next = wait_counter_reg;
        wait_reload_next  = wait_reload_reg;
        status_next       = dshsd_pkg::ST_OK;
        do_step           = 1'b0;
        do_finish         = 1'b0;
        set_wr            = 1'b0;
        query             = 1'b0;
        step_axis         = move_axis_reg;
        step_rev          = move_reverse_reg;

        wc_dec  = (wait_counter_reg != '0) ? wait_counter_reg - 1'b1 : '0;
        cnt_u   = step_count;
        mag     = step_count[STEP_BITS-1] ? (~cnt_u + 1'b1) : cnt_u;
        pin_bad = {1'b0, pin_number} >= 6'(NUM_PINS);
        slot    = dshsd_pkg::pin_slot(pin_number);

        case (op)
            dshsd_pkg::OP_TICK:
            begin
                if (move_active_reg)
                begin
                    wait_counter_next = wc_dec;
                    if (wc_dec == '0)
                    begin
                        if (steps_left_reg != '0)
                        begin
                            do_step           = 1'b1;
                            steps_left_next   = steps_left_reg - 1'b1;
                            wait_counter_next = wait_reload_reg;
                        end
                        else
                        begin
                            do_finish        = 1'b1;
                            move_active_next = 1'b0;
                        end
                    end
                end
            end
            dshsd_pkg::OP_MOVE:
            begin
                if (move_active_reg)
                begin
                    status_next = dshsd_pkg::ST_BUSY;
                end
                else if (step_count != '0)
                begin
                    do_step           = 1'b1;
                    step_axis         = axis;
                    step_rev          = step_count[STEP_BITS-1];
                    move_axis_next    = axis;
                    move_reverse_next = step_count[STEP_BITS-1];
                    steps_left_next   = mag - 1'b1;
                    wait_counter_next = step_delay;
                    wait_reload_next  = step_delay;
                    move_active_next  = 1'b1;
                end
            end
            dshsd_pkg::OP_SET, dshsd_pkg::OP_QUERY:
            begin
                if (move_active_reg)
                begin
                    status_next = dshsd_pkg::ST_BUSY;
                end
                else if (pin_bad)
                begin
                    status_next = dshsd_pkg::ST_RANGE;
                end
                else if (op == dshsd_pkg::OP_SET)
                begin
                    set_wr = 1'b1;
                end
                else
                begin
                    query = 1'b1;
                end
            end
            default:
            begin
                status_next = dshsd_pkg::ST_OK;
            end
        endcase

        // A step drives the moving motor's coils from the current phase;
        // the end of a move drives the same coils low.
        phase     = step_axis ? y_phase_reg : x_phase_reg;
        coil_bits = do_finish ? 4'b0000 : dshsd_pkg::phase_row(phase);
        phase_new = step_rev ? phase - 3'd1 : phase + 3'd1;
        step_slot = dshsd_pkg::pin_slot(dshsd_pkg::motor_pin(step_axis, 2'd0));

        req.en       = accept && (do_step || set_wr || query);
        req.row      = slot[dshsd_pkg::LANE_BITS +: dshsd_pkg::ROW_BITS];
        req.qlane    = slot[dshsd_pkg::LANE_BITS-1:0];
        req.inc_mask = '0;

        if (do_step || do_finish)
        begin
            req.row = step_slot[dshsd_pkg::LANE_BITS +: dshsd_pkg::ROW_BITS];
            for (int k = 0; k < dshsd_pkg::MEM_LANES; k++)
            begin
                mpin = dshsd_pkg::motor_pin(step_axis, 2'(k));
                req.inc_mask[k] = do_step && ({1'b0, mpin} < 6'(NUM_PINS));
                for (int n = 0; n < NUM_PINS; n++)
                begin
                    if ({1'b0, mpin} == 6'(n))
                    begin
                        levels_next[n] = coil_bits[k];
                    end
                end
            end
        end
        else
        begin
            mpin = '0;
        end

        if (do_step)
        begin
            ops_next = ops_reg + 1'b1;
            if (step_axis)
            begin
                y_phase_next = phase_new;
            end
            else
            begin
                x_phase_next = phase_new;
            end
        end

        if (set_wr)
        begin
            ops_next = ops_reg + 1'b1;
            req.inc_mask[req.qlane] = 1'b1;
            for (int n = 0; n < NUM_PINS; n++)
            begin
                if ({1'b0, pin_number} == 6'(n))
                begin
                    levels_next[n] = pin_value;
                end
            end
        end

        levels_wide = 32'(levels_next);
    end

    dshsd_count_mem #(
        .COUNT_BITS (COUNT_BITS)
    ) u_count_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cnt   (mem_cnt)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_phase_reg      <= '0;
            y_phase_reg      <= '0;
            levels_reg       <= '0;
            ops_reg          <= '0;
            move_active_reg  <= 1'b0;
            move_axis_reg    <= 1'b0;
            move_reverse_reg <= 1'b0;
            steps_left_reg   <= '0;
            wait_counter_reg <= '0;
            wait_reload_reg  <= '0;
            s1_valid_reg     <= 1'b0;
            q_head_reg       <= 1'b0;
            q_tail_reg       <= 1'b0;
            q_cnt_reg        <= '0;
        end
        else
        begin
            if (accept)
            begin
                x_phase_reg      <= x_phase_next;
                y_phase_reg      <= y_phase_next;
                levels_reg       <= levels_next;
                ops_reg          <= ops_next;
                move_active_reg  <= move_active_next;
                move_axis_reg    <= move_axis_next;
                move_reverse_reg <= move_reverse_next;
                steps_left_reg   <= steps_left_next;
                wait_counter_reg <= wait_counter_next;
                wait_reload_reg  <= wait_reload_next;
            end
            s1_valid_reg <= accept;
            if (s1_valid_reg)
            begin
                q_tail_reg <= ~q_tail_reg;
            end
            if (pop)
            begin
                q_head_reg <= ~q_head_reg;
            end
            q_cnt_reg <= q_cnt_reg + {1'b0, s1_valid_reg} - {1'b0, pop};
        end
    end

    // Payload registers: snapshot at acceptance, then queue entries.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_levels_reg <= levels_wide[LVB-1:0];
            s1_busy_reg   <= move_active_next;
            s1_ops_reg    <= ops_next;
            s1_status_reg <= status_next;
            s1_query_reg  <= query;
        end
        if (s1_valid_reg)
        begin
            q_levels[q_tail_reg] <= s1_levels_reg;
            q_busy[q_tail_reg]   <= s1_busy_reg;
            q_ops[q_tail_reg]    <= s1_ops_reg;
            q_cnt[q_tail_reg]    <= s1_query_reg ? mem_cnt : '0;
            q_status[q_tail_reg] <= s1_status_reg;
        end
    end

    assign out_valid       = (q_cnt_reg != 2'd0);
    assign pin_levels      = q_levels[q_head_reg];
    assign busy_res        = q_busy[q_head_reg];
    assign ops_total       = q_ops[q_head_reg];
    assign pin_write_count = q_cnt[q_head_reg];
    assign status          = q_status[q_head_reg];

    `ASSERT_ALWAYS(a_occ_bound, occ != 2'd3, "pipeline holds more beats than the queue can take")
    `ASSERT_ALWAYS(a_idle_no_steps, move_active_reg || (steps_left_reg == '0), "steps left while idle")
    `ASSERT_NEXT(a_busy_holds_pins, accept && (op != dshsd_pkg::OP_TICK) && move_active_reg, $stable(levels_reg) && $stable(ops_reg), "rejected command changed state")
    `ASSERT_NEXT(a_no_push_overflow, s1_valid_reg && !pop, q_cnt_reg != 2'd0, "result beat lost")

endmodule
